/* rtl/lfu_pkg.sv */
// shared types and constants for the lfu tier eviction table
package lfu_pkg;

    localparam int ENTRIES = 32;
    localparam int LEVELS = 10;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [47:0] FILE_BYTES = 48'd166289408;
    localparam logic [47:0] BYTES_MAX = {48{1'b1}};
    localparam logic [31:0] COUNT_MAX = {32{1'b1}};

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_ACCESS = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CHANGE = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_EVICT = 2'd1;
    localparam logic [1:0] ST_NOVICTIM = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [1:0] CFG_TOTAL = 2'd0;
    localparam logic [1:0] CFG_RESERVE = 2'd1;
    localparam logic [1:0] CFG_VICTIM = 2'd2;

    // datapath operations requested by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SCAN,      // clear search results, start sweep
        OP_STEP,      // examine one entry
        OP_INVAL,     // drop found entry (and refund if asked)
        OP_INSERT,    // write free slot
        OP_BUMP,      // increment count of found entry
        OP_EVICT,     // drop best victim, refund
        OP_CHARGE     // add file size
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic        use_new;    // match against new_level
        logic        refund;
        logic [31:0] ins_cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic found;
        logic free_ok;
        logic best_ok;
        logic over;
    } dp_stat_t;

endpackage

/* rtl/lfu_datapath.sv */
// entry table, sequential search unit and byte counter
module lfu_datapath import lfu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [30:0] file_id,
    input  logic [3:0]  level,
    input  logic [3:0]  new_level,
    input  logic [47:0] total_bytes,
    input  logic [47:0] reserve_bytes,
    input  logic [3:0]  victim_level,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [30:0] best_id,
    output logic [47:0] used_bytes
);

    logic [ENTRIES-1:0] valid_reg;
    logic [30:0] id_mem [ENTRIES];
    logic [3:0]  lvl_mem [ENTRIES];
    logic [31:0] cnt_mem [ENTRIES];

    logic [30:0] id_reg;
    logic [3:0]  lvl_reg, nlvl_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic        end_reg;
    logic        found_reg, free_ok_reg, best_ok_reg;
    logic [IDX_W-1:0] found_idx_reg, free_idx_reg, best_idx_reg;
    logic [31:0] best_cnt_reg;
    logic [30:0] best_id_reg;
    logic [47:0] used_reg;

    // registered read of the entry under the sweep pointer
    logic [30:0] rd_id_reg;
    logic [3:0]  rd_lvl_reg;
    logic [31:0] rd_cnt_reg;
    logic        rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic        rd_ok_reg;
    logic        rd_last_reg;

    logic [3:0]  match_lvl;
    logic [48:0] lim_sum;
    logic [47:0] charged;

    assign match_lvl = cmd.use_new ? nlvl_reg : lvl_reg;
    assign lim_sum = {1'b0, used_reg} + {1'b0, reserve_bytes};
    assign charged = ({1'b0, used_reg} + {1'b0, FILE_BYTES} > {1'b0, BYTES_MAX})
                     ? BYTES_MAX : used_reg + FILE_BYTES;

    assign stat.scan_end = end_reg;
    assign stat.found = found_reg;
    assign stat.free_ok = free_ok_reg;
    assign stat.best_ok = best_ok_reg;
    assign stat.over = lim_sum > {1'b0, total_bytes};
    assign best_id = best_id_reg;
    assign used_bytes = used_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg <= file_id;
            lvl_reg <= level;
            nlvl_reg <= new_level;
        end
        case (cmd.op)
            OP_SCAN: begin
                ptr_reg <= '0;
                end_reg <= 1'b0;
                found_reg <= 1'b0;
                free_ok_reg <= 1'b0;
                best_ok_reg <= 1'b0;
                rd_ok_reg <= 1'b0;
                rd_last_reg <= 1'b0;
            end
            OP_STEP: begin
                // examine the entry read in the previous cycle
                if (rd_ok_reg) begin
                    if (rd_valid_reg) begin
                        if (!found_reg && rd_id_reg == id_reg && rd_lvl_reg == match_lvl) begin
                            found_reg <= 1'b1;
                            found_idx_reg <= rd_idx_reg;
                        end
                        if ({1'b0, rd_lvl_reg} == {1'b0, victim_level} &&
                            (!best_ok_reg || rd_cnt_reg < best_cnt_reg ||
                             (rd_cnt_reg == best_cnt_reg && rd_id_reg < best_id_reg))) begin
                            best_ok_reg <= 1'b1;
                            best_idx_reg <= rd_idx_reg;
                            best_cnt_reg <= rd_cnt_reg;
                            best_id_reg <= rd_id_reg;
                        end
                    end else if (!free_ok_reg) begin
                        free_ok_reg <= 1'b1;
                        free_idx_reg <= rd_idx_reg;
                    end
                    if (rd_idx_reg == IDX_W'(ENTRIES - 1)) end_reg <= 1'b1;
                end
                // fetch the next entry
                if (!rd_last_reg) begin
                    rd_ok_reg <= 1'b1;
                    rd_idx_reg <= ptr_reg;
                    rd_id_reg <= id_mem[ptr_reg];
                    rd_lvl_reg <= lvl_mem[ptr_reg];
                    rd_cnt_reg <= cnt_mem[ptr_reg];
                    rd_valid_reg <= valid_reg[ptr_reg];
                    if (ptr_reg == IDX_W'(ENTRIES - 1)) rd_last_reg <= 1'b1;
                    else ptr_reg <= ptr_reg + 1'b1;
                end else begin
                    rd_ok_reg <= 1'b0;
                end
            end
            OP_INSERT: begin
                id_mem[free_idx_reg] <= id_reg;
                lvl_mem[free_idx_reg] <= match_lvl;
                cnt_mem[free_idx_reg] <= cmd.ins_cnt;
            end
            OP_BUMP: begin
                if (cnt_mem[found_idx_reg] != COUNT_MAX)
                    cnt_mem[found_idx_reg] <= cnt_mem[found_idx_reg] + 32'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg <= '0;
        end else begin
            case (cmd.op)
                OP_INVAL: begin
                    valid_reg[found_idx_reg] <= 1'b0;
                    if (cmd.refund)
                        used_reg <= (used_reg >= FILE_BYTES) ? used_reg - FILE_BYTES : '0;
                end
                OP_EVICT: begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    used_reg <= (used_reg >= FILE_BYTES) ? used_reg - FILE_BYTES : '0;
                end
                OP_INSERT: valid_reg[free_idx_reg] <= 1'b1;
                OP_CHARGE: used_reg <= charged;
                default: begin
                end
            endcase
        end
    end

    no_double_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_INSERT |-> free_ok_reg && !valid_reg[free_idx_reg])
        else $error("insert into occupied slot");
    evict_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EVICT |-> best_ok_reg && valid_reg[best_idx_reg])
        else $error("evict of invalid victim");
    charge_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_CHARGE |=> used_reg >= $past(used_reg))
        else $error("charge lowered byte total");

endmodule

/* rtl/lfu_ctrl.sv */
// command sequencer for the lfu table
module lfu_ctrl import lfu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [3:0]  s_level,
    input  logic [3:0]  s_new_level,
    output logic        load,
    output dp_cmd_t     dcmd,
    input  dp_stat_t    stat,
    input  logic [30:0] best_id,
    input  logic [47:0] used_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [30:0] m_victim_id,
    output logic [47:0] m_bytes_in_use,
    output logic        m_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_ACT, S_CHG_SCAN, S_CHG_ACT,
        S_CHECK, S_VSCAN, S_VACT, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  st_reg, st_next;
    logic [30:0] vid_reg, vid_next;
    logic        last_reg, last_next;
    logic        emit_after;  // go back to check after an eviction result

    logic emit_reg, emit_next;

    assign s_ready = state_reg == S_IDLE;
    assign load = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_status = st_reg;
    assign m_victim_id = vid_reg;
    assign m_bytes_in_use = used_bytes;
    assign m_last = last_reg;
    assign emit_after = emit_reg;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        out_valid_next = out_valid_reg;
        st_next = st_reg;
        vid_next = vid_reg;
        last_next = last_reg;
        emit_next = emit_reg;
        dcmd = '{op: OP_NONE, use_new: 1'b0, refund: 1'b0, ins_cnt: 32'd0};
        case (state_reg)
            S_IDLE: begin
                if (load) begin
                    op_next = s_cmd;
                    if ({1'b0, s_level} >= 5'(LEVELS) ||
                        (s_cmd == CMD_CHANGE && {1'b0, s_new_level} >= 5'(LEVELS))) begin
                        st_next = ST_DONE; vid_next = '0; last_next = 1'b1;
                        emit_next = 1'b0;
                        state_next = S_OUT;
                        out_valid_next = 1'b1;
                    end else begin
                        dcmd.op = OP_SCAN;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (stat.scan_end) state_next = S_ACT;
                else dcmd.op = OP_STEP;
            end
            S_ACT: begin
                st_next = ST_DONE; vid_next = '0; last_next = 1'b1; emit_next = 1'b0;
                state_next = S_OUT;
                case (op_reg)
                    CMD_ADD: begin
                        if (!stat.found) begin
                            if (!stat.free_ok) st_next = ST_FULL;
                            else begin
                                dcmd.op = OP_INSERT;
                                state_next = S_CHECK;
                            end
                        end
                    end
                    CMD_ACCESS: begin
                        if (stat.found) dcmd.op = OP_BUMP;
                        else if (stat.free_ok) begin
                            dcmd.op = OP_INSERT; dcmd.ins_cnt = 32'd1;
                        end else st_next = ST_FULL;
                    end
                    CMD_REMOVE: begin
                        if (stat.found) begin
                            dcmd.op = OP_INVAL; dcmd.refund = 1'b1;
                        end
                    end
                    default: begin
                        if (stat.found) dcmd.op = OP_INVAL;
                        state_next = S_CHG_SCAN;
                    end
                endcase
                if (state_next == S_OUT) begin
                    out_valid_next = 1'b1;
                end
            end
            S_CHG_SCAN: begin
                dcmd.op = OP_SCAN;
                state_next = S_CHG_ACT;
            end
            S_CHG_ACT: begin
                dcmd.use_new = 1'b1;
                if (!stat.scan_end) dcmd.op = OP_STEP;
                else begin
                    st_next = ST_DONE; vid_next = '0; last_next = 1'b1; emit_next = 1'b0;
                    if (!stat.found) begin
                        if (stat.free_ok) dcmd.op = OP_INSERT;
                        else st_next = ST_FULL;
                    end
                    state_next = S_OUT;
                    out_valid_next = 1'b1;
                end
            end
            S_CHECK: begin
                if (!emit_reg) dcmd.op = OP_CHARGE;
                state_next = S_VSCAN;
                emit_next = 1'b0;
            end
            S_VSCAN: begin
                if (!stat.over) begin
                    st_next = ST_DONE; vid_next = '0; last_next = 1'b1;
                    state_next = S_OUT; out_valid_next = 1'b1;
                end else begin
                    dcmd.op = OP_SCAN;
                    state_next = S_VACT;
                end
            end
            S_VACT: begin
                if (!stat.scan_end) dcmd.op = OP_STEP;
                else if (!stat.best_ok) begin
                    st_next = ST_NOVICTIM; vid_next = '0; last_next = 1'b1;
                    state_next = S_OUT; out_valid_next = 1'b1;
                end else begin
                    dcmd.op = OP_EVICT;
                    st_next = ST_EVICT; vid_next = best_id; last_next = 1'b0;
                    emit_next = 1'b1;
                    state_next = S_OUT; out_valid_next = 1'b1;
                end
            end
            S_OUT: begin
                // result holds until taken
                if (out_valid_reg && m_ready) begin
                    out_valid_next = 1'b0;
                    state_next = emit_after ? S_CHECK : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // results hold until taken; the byte total comes straight from the
    // datapath register, which sees no update while a result waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg <= CMD_ADD;
            emit_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            op_reg <= op_next;
            emit_reg <= emit_next;
        end
        st_reg <= st_next;
        vid_reg <= vid_next;
        last_reg <= last_next;
    end

    no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken with result pending");
    evict_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EVICT |-> !m_last)
        else $error("eviction marked last");
    other_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_EVICT |-> m_last)
        else $error("final result not marked last");

endmodule

/* rtl/lfu_tier_eviction_table.sv */
// top level of the lfu tier eviction table
// sweeps: a one-sweep command reads every entry once before it gives its result; a
// change-level command takes two sweeps, an inserting add one sweep plus one per victim
// search; an out-of-range level skips the sweep and answers at once
// throughput: one command at a time; the single-entry search loop sets the rate
// reset: aresetn synchronous active low, empties the table, clears the byte total
// and restores configuration and controller state defaults; no clearing pass is needed
module lfu_tier_eviction_table import lfu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [30:0] s_file_id,
    input  logic [3:0]  s_level,
    input  logic [3:0]  s_new_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [30:0] m_victim_id,
    output logic [47:0] m_bytes_in_use,
    output logic        m_last
);

    // configuration registers
    logic [47:0] total_reg, reserve_reg;
    logic [3:0]  victim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= BYTES_MAX;
            reserve_reg <= '0;
            victim_reg <= 4'd9;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TOTAL: total_reg <= cfg_data;
                CFG_RESERVE: reserve_reg <= cfg_data;
                CFG_VICTIM: victim_reg <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // controller to datapath command and status
    logic        load;
    dp_cmd_t     dcmd;
    dp_stat_t    stat;
    logic [30:0] best_id;
    logic [47:0] used_bytes;

    lfu_datapath u_dp (
        .aclk, .aresetn, .load,
        .file_id(s_file_id), .level(s_level), .new_level(s_new_level),
        .total_bytes(total_reg), .reserve_bytes(reserve_reg),
        .victim_level(victim_reg),
        .cmd(dcmd), .stat, .best_id, .used_bytes
    );

    // each result transaction carries the byte total after its update
    lfu_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_level, .s_new_level,
        .load, .dcmd, .stat, .best_id, .used_bytes,
        .m_valid, .m_ready, .m_status, .m_victim_id, .m_bytes_in_use, .m_last
    );

endmodule
